FILE: src/nmea_pkg.sv
// ----------------------------------------------------------------------------
// NMEA checksum checker package
// Shared types, constants and the hex digit decoder for the sentence checker.
// ----------------------------------------------------------------------------
package nmea_pkg;

    // Longest sentence that is counted, framing included.
    localparam int unsigned MAX_SENTENCE_LEN = 4096;
    // Framing bytes around the payload: '$', '*', two digits, CR and LF.
    localparam int unsigned FRAME_EXTRA      = 6;
    // Largest payload count before saturation.
    localparam int unsigned PAYLOAD_MAX      = MAX_SENTENCE_LEN - FRAME_EXTRA;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned LEN_W   = 13;

    // Characters with a framing role.
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;

    // Sentence phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HIGH    = 2'd2;
    localparam logic [1:0] PH_LOW     = 2'd3;

    // One result beat.
    typedef struct packed {
        logic               checksum_ok;
        logic [BYTE_W-1:0]  computed_sum;
        logic [BYTE_W-1:0]  received_sum;
        logic               bad_hex_digit;
        logic               too_long;
        logic [LEN_W-1:0]   sentence_length;
    } result_t;

    // Decoded checksum character: nibble value and a flag for a non-hex byte.
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit in either case; a non-hex byte reads as zero.
    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t d;
        logic [BYTE_W-1:0] diff;
        d    = '0;
        diff = '0;
        if (c >= 8'd48 && c <= 8'd57) begin
            diff = c - 8'd48;
        end else if (c >= 8'd65 && c <= 8'd70) begin
            diff = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd102) begin
            diff = c - 8'd87;
        end else begin
            d.bad = 1'b1;
        end
        d.value = diff[3:0];
        return d;
    endfunction

endpackage

FILE: src/nmea_if.sv
// ----------------------------------------------------------------------------
// NMEA checksum checker channels
// Valid/ready channels for received bytes and for sentence results.
// ----------------------------------------------------------------------------

// Byte channel: one received byte per beat.
interface nmea_byte_if;
    logic                        valid;
    logic                        ready;
    logic [nmea_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one checked sentence per beat.
interface nmea_result_if;
    logic              valid;
    logic              ready;
    nmea_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/nmea_sentence_checksum_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker
// Frames sentences from a byte stream, XORs the payload and checks it against
// the two hex digits that follow the '*'.
//
//   Channel  Modport  Payload                               Per beat
//   rx       sink     rx_byte                               one received byte
//   result   source   checksum_ok, computed_sum,            one sentence
//                     received_sum, bad_hex_digit,
//                     too_long, sentence_length
//
// The checker has no busy state and can take a new byte right after the last.
// The result of a sentence is registered into the output register as the
// second checksum digit is accepted.
// A byte is refused only while a result beat waits in the output register and
// the sink does not take it in the same cycle.
// Reset returns the block to idle, outside any sentence, with no result held.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_checker (
    input logic          clk,
    input logic          rst_n,
    nmea_byte_if.sink    rx,
    nmea_result_if.source result
);
    import nmea_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         high_reg, high_next;
    logic               digit_err_reg, digit_err_next;
    logic               overflow_reg, overflow_next;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               accept;
    logic               emit;
    hex_digit_t         digit;
    logic               err_now;
    logic [BYTE_W-1:0]  rx_sum;
    logic [LEN_W:0]     len_full;

    // The output register frees up when it is empty or being taken this cycle.
    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    assign digit    = hex_decode(rx.rx_byte);
    assign err_now  = digit_err_reg || digit.bad;
    assign rx_sum   = {high_reg, digit.value};
    assign len_full = {1'b0, count_reg} + (LEN_W+1)'(FRAME_EXTRA);

    // Sentence framing and accumulation for one accepted byte.
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        count_next     = count_reg;
        high_next      = high_reg;
        digit_err_next = digit_err_reg;
        overflow_next  = overflow_reg;
        emit           = 1'b0;
        if (accept) begin
            if (rx.rx_byte == CHAR_DOLLAR) begin
                phase_next     = PH_PAYLOAD;
                xor_next       = '0;
                count_next     = '0;
                high_next      = '0;
                digit_err_next = 1'b0;
                overflow_next  = 1'b0;
            end else begin
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        if (rx.rx_byte == CHAR_STAR) begin
                            phase_next = PH_HIGH;
                        end else begin
                            xor_next = xor_reg ^ rx.rx_byte;
                            if (count_reg >= COUNT_W'(PAYLOAD_MAX)) begin
                                overflow_next = 1'b1;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    PH_HIGH:
                    begin
                        high_next      = digit.value;
                        digit_err_next = err_now;
                        phase_next     = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        digit_err_next = err_now;
                        phase_next     = PH_IDLE;
                        emit           = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result assembly and output register hand-off.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (result.ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next           = 1'b1;
            out_next.computed_sum    = xor_reg;
            out_next.received_sum    = rx_sum;
            out_next.bad_hex_digit   = err_now;
            out_next.too_long        = overflow_reg;
            out_next.checksum_ok     = !err_now && !overflow_reg && (rx_sum == xor_reg);
            if (len_full > (LEN_W+1)'(MAX_SENTENCE_LEN)) begin
                out_next.sentence_length = LEN_W'(MAX_SENTENCE_LEN);
            end else begin
                out_next.sentence_length = len_full[LEN_W-1:0];
            end
        end
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            xor_reg       <= '0;
            count_reg     <= '0;
            high_reg      <= '0;
            digit_err_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            count_reg     <= count_next;
            high_reg      <= high_next;
            digit_err_reg <= digit_err_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

FILE: tb/nmea_sentence_checksum_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker testbench
// Drives a byte stream of well-formed, broken and overlong sentences through
// the checker, mixed with idle noise. The stimulus starts with a short table
// of directed bytes and then moves to random sentences. An in-bench sentence
// model predicts the untyped result beats; each is compared field by field.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the checker has to stall its byte input.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_checker_tb;

    import nmea_pkg::*;

    localparam int unsigned RANDOM_BYTES = 650;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int          N_DIRECTED   = 27;

    // Line end characters, which the checker ignores while idle.
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              has_exp;
        result_t           exp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    nmea_byte_if   rx_ch ();
    nmea_result_if res_ch ();

    nmea_sentence_checksum_checker u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // Directed bytes; the result of a row is typed in where it is obvious.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00,       1'b0, '0},
        '{8'hFF,       1'b0, '0},
        // Empty payload with checksum 00.
        '{CHAR_DOLLAR, 1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{8'h30,       1'b0, '0},
        '{8'h30,       1'b1, '{1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 13'd6}},
        // Single payload byte 'A' with checksum 41.
        '{CHAR_DOLLAR, 1'b0, '0},
        '{8'h41,       1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{8'h34,       1'b0, '0},
        '{8'h31,       1'b1, '{1'b1, 8'h41, 8'h41, 1'b0, 1'b0, 13'd7}},
        // Two invalid checksum characters: 'g' and a star.
        '{CHAR_DOLLAR, 1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{8'h67,       1'b0, '0},
        '{CHAR_STAR,   1'b1, '{1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 13'd6}},
        // A dollar in the payload, in the high digit and in the low digit.
        '{CHAR_DOLLAR, 1'b0, '0},
        '{8'h61,       1'b0, '0},
        '{CHAR_DOLLAR, 1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{CHAR_DOLLAR, 1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{8'h66,       1'b0, '0},
        '{CHAR_DOLLAR, 1'b0, '0},
        // Then a payload of 0xFF with mixed-case digits.
        '{8'hFF,       1'b0, '0},
        '{CHAR_STAR,   1'b0, '0},
        '{8'h66,       1'b0, '0},
        '{8'h46,       1'b1, '{1'b1, 8'hFF, 8'hFF, 1'b0, 1'b0, 13'd7}}
    };

    // Sentence model state.
    logic [1:0]         sm_phase;
    logic [BYTE_W-1:0]  sm_xor;
    logic [COUNT_W-1:0] sm_count;
    logic [3:0]         sm_high;
    logic               sm_digit_err;
    logic               sm_overflow;

    result_t     pending_results [$];
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned bytes_sent;
    int unsigned counted_bytes;
    int unsigned cycle_count;
    bit          quiet;
    bit          hold_req;
    int unsigned hold_left;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Value of one checksum character; returns 1 when it is not a hex digit.
    function automatic bit hex_nibble(input logic [BYTE_W-1:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c[3:0];
            return 1'b0;
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = c[3:0] + 4'd9;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // ASCII character of a nibble, upper or lower case.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'h30 + n;
        end
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // Advances the sentence model by one byte; returns 1 when a result is due.
    function automatic bit sentence_step(input logic [BYTE_W-1:0] c, output result_t r);
        logic [3:0]  nib;
        bit          bad;
        int unsigned len;
        r = '0;
        if (c == CHAR_DOLLAR)
        begin
            sm_phase     = PH_PAYLOAD;
            sm_xor       = '0;
            sm_count     = '0;
            sm_high      = '0;
            sm_digit_err = 1'b0;
            sm_overflow  = 1'b0;
            return 1'b0;
        end
        case (sm_phase)
            PH_PAYLOAD:
            begin
                if (c == CHAR_STAR)
                begin
                    sm_phase = PH_HIGH;
                end
                else
                begin
                    sm_xor = sm_xor ^ c;
                    if (sm_count >= PAYLOAD_MAX)
                        sm_overflow = 1'b1;
                    else
                        sm_count = sm_count + 1'b1;
                end
            end
            PH_HIGH:
            begin
                bad     = hex_nibble(c, nib);
                sm_high = nib;
                if (bad)
                    sm_digit_err = 1'b1;
                sm_phase = PH_LOW;
            end
            PH_LOW:
            begin
                bad = hex_nibble(c, nib);
                if (bad)
                    sm_digit_err = 1'b1;
                len = int'(sm_count) + FRAME_EXTRA;
                if (len > MAX_SENTENCE_LEN)
                    len = MAX_SENTENCE_LEN;
                r.computed_sum    = sm_xor;
                r.received_sum    = {sm_high, nib};
                r.bad_hex_digit   = sm_digit_err;
                r.too_long        = sm_overflow;
                r.sentence_length = LEN_W'(len);
                r.checksum_ok     = !sm_digit_err && !sm_overflow && (r.received_sum == sm_xor);
                sm_phase = PH_IDLE;
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // Offers one byte with random idle cycles and waits for its beat.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input result_t typed_res = '0);
        result_t r;
        bit      due;
        while (!quiet && $urandom_range(99) < 33)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
        due = sentence_step(b, r);
        if (typed)
            pending_results.push_back(typed_res);
        else if (due)
            pending_results.push_back(r);
    endtask

    // One random sentence with a payload of plen bytes, then an optional line end and noise.
    task automatic send_sentence(input int unsigned plen, input bit may_break);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] hi_c;
        logic [BYTE_W-1:0] lo_c;
        int unsigned       pick;
        int unsigned       break_at;
        sum      = '0;
        pick     = may_break ? $urandom_range(99) : 0;
        break_at = (may_break && $urandom_range(99) < 5) ? $urandom_range(plen) : plen + 1;
        send_byte(CHAR_DOLLAR);
        counted_bytes++;
        for (int unsigned i = 0; i < plen; i++)
        begin
            ch = BYTE_W'($urandom_range(255));
            // A sentence that must stay whole never carries a framing character.
            if (i == break_at)
                ch = CHAR_DOLLAR;
            else if ((ch == CHAR_DOLLAR || ch == CHAR_STAR) &&
                     (!may_break || $urandom_range(3) != 0))
                ch = ch ^ 8'h01;
            if (ch == CHAR_DOLLAR)
                sum = '0;
            else
                sum = sum ^ ch;
            send_byte(ch);
            counted_bytes++;
        end
        send_byte(CHAR_STAR);
        counted_bytes++;
        hi_c = hex_char(sum[7:4], 1'($urandom_range(1)));
        lo_c = hex_char(sum[3:0], 1'($urandom_range(1)));
        if (pick >= 70 && pick < 85)
        begin
            hi_c = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
            lo_c = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
        end
        else if (pick >= 85 && pick < 95)
        begin
            if ($urandom_range(1))
                hi_c = BYTE_W'($urandom_range(255));
            else
                lo_c = BYTE_W'($urandom_range(255));
        end
        else if (pick >= 95)
        begin
            // A dollar in one of the digit positions abandons the sentence.
            if ($urandom_range(1))
                hi_c = CHAR_DOLLAR;
            else
                lo_c = CHAR_DOLLAR;
        end
        send_byte(hi_c);
        send_byte(lo_c);
        counted_bytes += 2;
        if ($urandom_range(9) < 7)
        begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
        // Noise between sentences, never a dollar.
        repeat ($urandom_range(3))
        begin
            ch = BYTE_W'($urandom_range(255));
            if (ch == CHAR_DOLLAR)
                ch = ch ^ 8'h01;
            send_byte(ch);
        end
    endtask

    // Logs one field mismatch.
    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                 $time, name, want, want, got, got);
        error_count++;
    endfunction

    // Compares a result beat with the oldest pending expectation.
    function automatic void check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result beat with nothing expected, expected none, actual %p",
                     $time, got);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (got.checksum_ok !== want.checksum_ok)
            report_field("checksum_ok", want.checksum_ok, got.checksum_ok);
        if (got.computed_sum !== want.computed_sum)
            report_field("computed_sum", want.computed_sum, got.computed_sum);
        if (got.received_sum !== want.received_sum)
            report_field("received_sum", want.received_sum, got.received_sum);
        if (got.bad_hex_digit !== want.bad_hex_digit)
            report_field("bad_hex_digit", want.bad_hex_digit, got.bad_hex_digit);
        if (got.too_long !== want.too_long)
            report_field("too_long", want.too_long, got.too_long);
        if (got.sentence_length !== want.sentence_length)
            report_field("sentence_length", want.sentence_length, got.sentence_length);
    endfunction

    // Result sink: checks each beat and drives ready, with one long hold-off.
    initial
    begin
        res_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.payload);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= quiet || ($urandom_range(99) >= 33);
            end
        end
    end

    // Watchdog on the length of the run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still expected",
                 $time, cycle_count, pending_results.size());
        $display("nmea_sentence_checksum_checker_tb NOT OK");
        $finish;
    end

    // Reset, stimulus and end of run.
    initial
    begin
        int unsigned sentence_no;
        int unsigned plen;
        error_count   = 0;
        results_seen  = 0;
        bytes_sent    = 0;
        counted_bytes = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        sm_phase      = PH_IDLE;
        sm_xor        = '0;
        sm_count      = '0;
        sm_high       = '0;
        sm_digit_err  = 1'b0;
        sm_overflow   = 1'b0;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_byte(directed_rows[i].ch, directed_rows[i].has_exp, directed_rows[i].exp);
        end

        // Random sentences, with one result hold-off and one stretch without idling.
        sentence_no = 0;
        while (counted_bytes < RANDOM_BYTES)
        begin
            if (sentence_no == 15)
                hold_req = 1'b1;
            quiet = (sentence_no >= 30 && sentence_no < 45);
            plen  = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
            send_sentence(plen, 1'b1);
            sentence_no++;
        end

        // Longest payloads: at the bound, one past it, and well past it.
        quiet = 1'b1;
        send_sentence(PAYLOAD_MAX, 1'b0);
        send_sentence(PAYLOAD_MAX + 1, 1'b0);
        send_sentence($urandom_range(PAYLOAD_MAX + 60, PAYLOAD_MAX + 2), 1'b0);
        quiet = 1'b0;

        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d random sentences after %0d directed bytes.",
                 bytes_sent, sentence_no + 3, N_DIRECTED);
        $display("Checked %0d result beats, %0d mismatches.", results_seen, error_count);
        if (error_count == 0)
            $display("nmea_sentence_checksum_checker_tb OK");
        else
            $display("nmea_sentence_checksum_checker_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/nmea_pkg.sv
src/nmea_if.sv
src/nmea_sentence_checksum_checker.sv
tb/nmea_sentence_checksum_checker_tb.sv
